// ===== hw/rtl/fresnel_reflectance_defines.svh =====
// assertion macros for the fresnel reflectance block
// used by the top level only; expects aclk and aresetn in scope
`ifndef FRESNEL_REFLECTANCE_DEFINES_SVH
`define FRESNEL_REFLECTANCE_DEFINES_SVH

// implication checked while out of reset
`define FRSN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fresnel_reflectance check failed");

// next-cycle implication checked at every edge, reset included
`define FRSN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("fresnel_reflectance check failed");

`endif

// ===== hw/rtl/frsn_pkg.sv =====
// shared widths, constants and types for the fresnel reflectance pipeline
// no dependencies
package frsn_pkg;

    localparam int COS_W       = 16;
    localparam int IDX_W       = 14;
    localparam int A_W         = 15;
    localparam int OUT_W       = 16;
    localparam int D_W         = 56;
    localparam int R_W         = 28;
    localparam int SQRT_STAGES = 28;
    localparam int RATIO_BITS  = 20;
    localparam int Q_W         = RATIO_BITS + 1;
    localparam int DEN_S_W     = 44;
    localparam int DEN_P_W     = 30;

    localparam logic [A_W-1:0]   ONE_Q14 = 15'd16384;
    localparam logic [IDX_W-1:0] ONE_Q12 = 14'd4096;
    localparam logic [OUT_W-1:0] ONE_Q15 = 16'd32768;

    typedef struct packed {
        logic             tir;
        logic             pos;
        logic [A_W-1:0]   a;
        logic [IDX_W-1:0] n;
        logic [27:0]      nsq;
    } frsn_side_t;

endpackage

// ===== hw/rtl/frsn_front.sv =====
// front pipeline: operand clamping, squares, total reflection test and sqrt radicand
// depends on frsn_pkg
module frsn_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [frsn_pkg::COS_W-1:0]          cos_incident,
    input  logic [frsn_pkg::IDX_W-1:0]          refractive_index,
    output logic                                out_valid,
    output logic [frsn_pkg::D_W-1:0]            out_d,
    output frsn_pkg::frsn_side_t                out_side
);

    logic [16:0]                     mag_next;
    logic [frsn_pkg::A_W-1:0]        a_next;
    logic [frsn_pkg::IDX_W-1:0]      n_next;
    logic                            pos_next;

    logic [4:0]                      v_reg;
    logic [frsn_pkg::A_W-1:0]        a1_reg, a2_reg, a3_reg, a4_reg;
    logic [frsn_pkg::IDX_W-1:0]      n1_reg, n2_reg, n3_reg, n4_reg;
    logic                            pos1_reg, pos2_reg, pos3_reg, pos4_reg;
    logic [28:0]                     asq2_reg;
    logic [27:0]                     nsq2_reg, nsq3_reg, nsq4_reg;
    logic [28:0]                     s2_3_reg, s2_4_reg;
    logic [42:0]                     pphi4_reg;
    logic [41:0]                     pplo4_reg;
    logic [56:0]                     lhs_next, rhs_next, diff_next;
    logic [frsn_pkg::D_W-1:0]        d_reg;
    frsn_pkg::frsn_side_t            side_reg;

    always_comb begin
        mag_next = cos_incident[15] ? (17'h10000 - {1'b0, cos_incident})
                                    : {1'b0, cos_incident};
        a_next   = (mag_next > {2'b00, frsn_pkg::ONE_Q14}) ? frsn_pkg::ONE_Q14
                                                             : mag_next[14:0];
        n_next   = (refractive_index < frsn_pkg::ONE_Q12) ? frsn_pkg::ONE_Q12
                                                            : refractive_index;
        pos_next = (cos_incident != '0) && !cos_incident[15];
    end

    // leaving the medium: lhs = n^2 * sin^2, rhs = 2^52
    // entering: lhs = 2^24 * sin^2, rhs = n^2 * 2^28
    always_comb begin
        if (pos4_reg) begin
            lhs_next = {pphi4_reg, 14'b0} + {15'b0, pplo4_reg};
            rhs_next = 57'd1 << 52;
        end else begin
            lhs_next = {4'b0, s2_4_reg, 24'b0};
            rhs_next = {1'b0, nsq4_reg, 28'b0};
        end
        diff_next = rhs_next - lhs_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a_next;
            n1_reg   <= n_next;
            pos1_reg <= pos_next;

            a2_reg   <= a1_reg;
            n2_reg   <= n1_reg;
            pos2_reg <= pos1_reg;
            asq2_reg <= 29'(a1_reg * a1_reg);
            nsq2_reg <= 28'(n1_reg * n1_reg);

            a3_reg   <= a2_reg;
            n3_reg   <= n2_reg;
            pos3_reg <= pos2_reg;
            nsq3_reg <= nsq2_reg;
            s2_3_reg <= (29'd1 << 28) - asq2_reg;

            a4_reg    <= a3_reg;
            n4_reg    <= n3_reg;
            pos4_reg  <= pos3_reg;
            nsq4_reg  <= nsq3_reg;
            s2_4_reg  <= s2_3_reg;
            pphi4_reg <= 43'(nsq3_reg * s2_3_reg[28:14]);
            pplo4_reg <= 42'(nsq3_reg * s2_3_reg[13:0]);

            d_reg        <= diff_next[55:0];
            side_reg.tir <= diff_next[56] || (diff_next == '0);
            side_reg.pos <= pos4_reg;
            side_reg.a   <= a4_reg;
            side_reg.n   <= n4_reg;
            side_reg.nsq <= nsq4_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign out_d     = d_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/frsn_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on frsn_pkg
module frsn_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [frsn_pkg::D_W-1:0]     in_d,
    input  frsn_pkg::frsn_side_t         in_side,
    output logic                         out_valid,
    output logic [frsn_pkg::R_W-1:0]     out_root,
    output frsn_pkg::frsn_side_t         out_side
);

    localparam int N = frsn_pkg::SQRT_STAGES;
    localparam int W = frsn_pkg::D_W;

    logic [N-1:0]         v_reg;
    logic [W-1:0]         rem_reg  [N];
    logic [W-1:0]         root_reg [N];
    frsn_pkg::frsn_side_t side_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int SH = 2 * (N - 1 - k);
        logic [W-1:0]         rem_src, root_src;
        frsn_pkg::frsn_side_t side_src;
        logic [W:0]           trial;
        logic                 ge;
        logic [W-1:0]         rem_next, root_next;

        if (k == 0) begin : g_first
            assign rem_src  = in_d;
            assign root_src = '0;
            assign side_src = in_side;
        end else begin : g_rest
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_comb begin
            trial     = {1'b0, root_src} + ((W+1)'(1) << SH);
            ge        = {1'b0, rem_src} >= trial;
            rem_next  = ge ? (rem_src - trial[W-1:0]) : rem_src;
            root_next = ge ? ((root_src >> 1) + (W'(1) << SH)) : (root_src >> 1);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1][frsn_pkg::R_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hw/rtl/frsn_div.sv =====
// pipelined restoring divider for |p-q|/(p+q) in Q1.20, rounded half up
// depends on frsn_pkg
module frsn_div #(
    parameter int DEN_W = frsn_pkg::DEN_S_W
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [DEN_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    output logic [frsn_pkg::Q_W-1:0]   quot
);

    localparam int QW    = frsn_pkg::Q_W;
    localparam int REM_W = DEN_W + frsn_pkg::RATIO_BITS + 1;

    logic [REM_W-1:0] rem_reg  [QW];
    logic [DEN_W-1:0] den_reg  [QW];
    logic [QW-1:0]    q_reg    [QW];
    logic             zero_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BI = QW - 1 - k;
        logic [REM_W-1:0] rem_src, sh, rem_next;
        logic [DEN_W-1:0] den_src;
        logic [QW-1:0]    q_src, q_next;
        logic             zero_src, ge;

        if (k == 0) begin : g_first
            assign rem_src  = ({1'b0, num, frsn_pkg::RATIO_BITS'(0)})
                            + REM_W'(den >> 1);
            assign den_src  = den;
            assign q_src    = '0;
            assign zero_src = (den == '0);
        end else begin : g_rest
            assign rem_src  = rem_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign q_src    = q_reg[k-1];
            assign zero_src = zero_reg[k-1];
        end

        always_comb begin
            sh       = REM_W'(den_src) << BI;
            ge       = rem_src >= sh;
            rem_next = ge ? (rem_src - sh) : rem_src;
            q_next   = q_src | (QW'(ge) << BI);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_src;
                q_reg[k]    <= q_next;
                zero_reg[k] <= zero_src;
            end
        end
    end

    // a zero denominator reads as a ratio of one
    assign quot = zero_reg[QW-1] ? (QW'(1) << frsn_pkg::RATIO_BITS) : q_reg[QW-1];

endmodule

// ===== hw/rtl/fresnel_reflectance.sv =====
// top level of the unpolarized dielectric fresnel reflectance pipeline
// depends on frsn_pkg, frsn_front, frsn_sqrt, frsn_div, fresnel_reflectance_defines.svh
//
// s_ channel: one transfer per query, tdata carries the signed Q2.14 cosine
// between normal and ray and the Q2.12 surface index (outside index is 1).
// m_ channel: one transfer per query, tdata carries the Q1.15 reflectance,
// tuser flags total internal reflection (reflectance then reads 1.0).
// results leave in the order the queries came in.
// path: from the input transfer to m_tvalid a query passes 5 front stages,
// 28 square root stages (one root bit each), 2 ratio operand stages,
// 21 divider stages (one quotient bit each), a squaring stage and the
// output register.
// throughput: one query per cycle; every stage is a register, so a new query
// enters at each edge while the output is not stalled.
// stall: when m_tvalid is high and m_tready is low the whole pipeline holds
// and s_tready drops; nothing is dropped or repeated.
// reset: aresetn low for one edge empties the pipeline; no clearing pass,
// s_tready is high in the first cycle after reset.
`include "fresnel_reflectance_defines.svh"

module fresnel_reflectance (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cos_incident[15:0], refractive_index[29:16], zero[31:30]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // reflectance[15:0]
    output logic        m_tuser    // total_reflection[0]
);

    localparam int QW = frsn_pkg::Q_W;

    logic                         en;
    logic                         fr_valid, sq_valid;
    logic [frsn_pkg::D_W-1:0]     fr_d;
    frsn_pkg::frsn_side_t         fr_side, sq_side;
    logic [frsn_pkg::R_W-1:0]     sq_root;

    // ratio operand stage
    logic                         vm_reg, tirm_reg, posm_reg;
    logic [frsn_pkg::A_W-1:0]     am_reg;
    logic [frsn_pkg::R_W-1:0]     rm_reg;
    logic [42:0]                  prods_reg;
    logic [28:0]                  prodp_reg;
    logic [27:0]                  mulx_next, muly_next;

    // numerator and denominator stage
    logic                         vn_reg, tirn_reg;
    logic [42:0]                  ps_next, qs_next;
    logic [28:0]                  pp_next, qp_next;
    logic [frsn_pkg::DEN_S_W-1:0] nums_reg, dens_reg;
    logic [frsn_pkg::DEN_P_W-1:0] nump_reg, denp_reg;

    logic [QW-1:0]                vd_reg, tird_reg;
    logic [QW-1:0]                rs_q, rp_q;

    logic                         vsq_reg, tirsq_reg;
    logic [41:0]                  sqs_reg, sqp_reg;
    logic [42:0]                  sum_next;
    logic [16:0]                  kr_next;
    logic [15:0]                  refl_next;

    logic                         m_tvalid_reg, m_tuser_reg;
    logic [15:0]                  m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    frsn_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_valid         (s_tvalid),
        .cos_incident     (s_tdata[15:0]),
        .refractive_index (s_tdata[29:16]),
        .out_valid        (fr_valid),
        .out_d            (fr_d),
        .out_side         (fr_side)
    );

    frsn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_d      (fr_d),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // leaving: rs = (a*2^24 - n*r) / (...), entering: rs = (n^2*a - r*2^12) / (...)
    always_comb begin
        mulx_next = sq_side.pos ? {14'b0, sq_side.n} : sq_side.nsq;
        muly_next = sq_side.pos ? sq_root : {13'b0, sq_side.a};
    end

    always_comb begin
        ps_next = posm_reg ? {4'b0, am_reg, 24'b0} : prods_reg;
        qs_next = posm_reg ? prods_reg : {3'b0, rm_reg, 12'b0};
        pp_next = posm_reg ? prodp_reg : {2'b0, am_reg, 12'b0};
        qp_next = {1'b0, rm_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg       <= 1'b0;
            vn_reg       <= 1'b0;
            vd_reg       <= '0;
            vsq_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vm_reg       <= sq_valid;
            vn_reg       <= vm_reg;
            vd_reg       <= {vd_reg[QW-2:0], vn_reg};
            vsq_reg      <= vd_reg[QW-1];
            m_tvalid_reg <= vsq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tirm_reg  <= sq_side.tir;
            posm_reg  <= sq_side.pos;
            am_reg    <= sq_side.a;
            rm_reg    <= sq_root;
            prods_reg <= 43'(mulx_next * muly_next);
            prodp_reg <= 29'(sq_side.n * sq_side.a);

            tirn_reg <= tirm_reg;
            nums_reg <= {1'b0, (ps_next >= qs_next) ? (ps_next - qs_next)
                                                    : (qs_next - ps_next)};
            dens_reg <= {1'b0, ps_next} + {1'b0, qs_next};
            nump_reg <= {1'b0, (pp_next >= qp_next) ? (pp_next - qp_next)
                                                    : (qp_next - pp_next)};
            denp_reg <= {1'b0, pp_next} + {1'b0, qp_next};

            tird_reg <= {tird_reg[QW-2:0], tirn_reg};

            tirsq_reg <= tird_reg[QW-1];
            sqs_reg   <= 42'(rs_q * rs_q);
            sqp_reg   <= 42'(rp_q * rp_q);

            m_tuser_reg <= tirsq_reg;
            m_tdata_reg <= refl_next;
        end
    end

    frsn_div #(.DEN_W(frsn_pkg::DEN_S_W)) u_div_s (
        .aclk (aclk),
        .en   (en),
        .num  (nums_reg),
        .den  (dens_reg),
        .quot (rs_q)
    );

    frsn_div #(.DEN_W(frsn_pkg::DEN_P_W)) u_div_p (
        .aclk (aclk),
        .en   (en),
        .num  (nump_reg),
        .den  (denp_reg),
        .quot (rp_q)
    );

    // mean of the squared ratios: (rs^2 + rp^2) / 2 in Q1.15, rounded
    always_comb begin
        sum_next = {1'b0, sqs_reg} + {1'b0, sqp_reg} + (43'd1 << 25);
        kr_next  = sum_next[42:26];
        if (tirsq_reg || (kr_next > {1'b0, frsn_pkg::ONE_Q15})) begin
            refl_next = frsn_pkg::ONE_Q15;
        end else begin
            refl_next = kr_next[15:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FRSN_ASSERT_IMPL(a_tir_full, m_tvalid && m_tuser, m_tdata == frsn_pkg::ONE_Q15)
    `FRSN_ASSERT_IMPL(a_refl_range, m_tvalid, m_tdata <= frsn_pkg::ONE_Q15)
    `FRSN_ASSERT_NEXT(a_reset_empty, !aresetn, !m_tvalid && s_tready)

endmodule

// ===== bench/fresnel_reflectance_tb.sv =====
// self-checking bench for the fresnel reflectance pipeline: directed corners, then random
// queries under three sender/receiver idling mixes; depends on frsn_pkg and the rtl top level
module fresnel_reflectance_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 58;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [frsn_pkg::OUT_W-1:0] reflectance;
        logic                       total_reflection;
    } reflect_t;

    class reflect_scoreboard;
        reflect_t awaited[$];
        int       errors;

        // integer square root, floor
        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // |p - q| / (p + q) in Q1.20, rounded half up
        function automatic longint unsigned amp_ratio(longint unsigned p, longint unsigned q);
            longint unsigned num;
            longint unsigned den;
            num = (p >= q) ? p - q : q - p;
            den = p + q;
            if (den == 0) return 64'd1 << frsn_pkg::RATIO_BITS;
            return ((num << frsn_pkg::RATIO_BITS) + den / 2) / den;
        endfunction

        function automatic reflect_t fresnel_of(logic [frsn_pkg::COS_W-1:0] c,
                                                logic [frsn_pkg::IDX_W-1:0] n);
            reflect_t        res;
            longint unsigned a, idx, n1, n2, s2, lhs, rhs, r, rs, rp, kr;
            bit              leaving;
            leaving = (c != 0) && !c[frsn_pkg::COS_W-1];
            a = c[frsn_pkg::COS_W-1] ? 64'h10000 - c : c;
            if (a > frsn_pkg::ONE_Q14) a = frsn_pkg::ONE_Q14;
            idx = (n < frsn_pkg::ONE_Q12) ? frsn_pkg::ONE_Q12 : n;
            n1 = leaving ? idx : frsn_pkg::ONE_Q12;
            n2 = leaving ? frsn_pkg::ONE_Q12 : idx;
            s2 = 64'd1 << 28;
            s2 = s2 - a * a;
            lhs = n1 * n1 * s2;
            rhs = (n2 * n2) << 28;
            if (lhs >= rhs) begin
                res.reflectance = frsn_pkg::ONE_Q15;
                res.total_reflection = 1'b1;
                return res;
            end
            r = root_floor(rhs - lhs);
            rs = amp_ratio(n2 * n2 * a, n1 * r);
            rp = amp_ratio(n1 * a, r);
            kr = (rs * rs + rp * rp + (64'd1 << 25)) >> 26;
            if (kr > frsn_pkg::ONE_Q15) kr = frsn_pkg::ONE_Q15;
            res.reflectance = kr[frsn_pkg::OUT_W-1:0];
            res.total_reflection = 1'b0;
            return res;
        endfunction

        function void note_query(logic [frsn_pkg::COS_W-1:0] c, logic [frsn_pkg::IDX_W-1:0] n);
            awaited.insert(awaited.size(), fresnel_of(c, n));
        endfunction

        function void check_result(logic [frsn_pkg::OUT_W-1:0] refl, logic tir);
            reflect_t exp_r;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result reflectance %0d tir %0d", $time, refl, tir);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            if (refl !== exp_r.reflectance) begin
                $display("%0t: reflectance expected %0d actual %0d", $time,
                         exp_r.reflectance, refl);
                errors++;
            end
            if (tir !== exp_r.total_reflection) begin
                $display("%0t: total_reflection expected %0d actual %0d", $time,
                         exp_r.total_reflection, tir);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    reflect_scoreboard sb;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                cycles;

    fresnel_reflectance DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cos_incident[15:0], refractive_index[29:16], zero[31:30]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // reflectance[15:0]
        .m_tuser  (m_tuser)    // total_reflection[0]
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    task automatic send_query(logic [frsn_pkg::COS_W-1:0] c, logic [frsn_pkg::IDX_W-1:0] n);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, n, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_query(c, n);
    endtask

    task automatic send_random_query();
        logic [frsn_pkg::COS_W-1:0] c;
        logic [frsn_pkg::IDX_W-1:0] n;
        int                         pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            // raw fields, out-of-range values included
            c = 16'($urandom);
            n = 14'($urandom);
        end else begin
            c = 16'($urandom_range(32768) - 16384);
            n = 14'((pick < 65) ? $urandom_range(8192, 4096) : $urandom_range(16383, 4096));
        end
        send_query(c, n);
    endtask

    initial begin
        logic [frsn_pkg::COS_W-1:0] corner_cos[9];
        logic [frsn_pkg::IDX_W-1:0] corner_idx[4];

        sb = new();
        cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 53;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        corner_cos = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd32767, 16'h8000,
                       16'sd1, -16'sd1, 16'sd11585, -16'sd11585};
        corner_idx = '{14'd0, 14'd4096, 14'd6144, 14'd16383};
        for (int i = 0; i < 9; i++) send_query(corner_cos[i], corner_idx[i % 4]);
        // leaving a dense medium at a grazing angle: total internal reflection
        send_query(16'sd100, 14'd6144);
        send_query(16'sd8000, 14'd16383);
        send_query(16'sd16384, 14'd16383);
        send_query(-16'sd16384, 14'd16383);
        send_query(-16'sd1, 14'd16383);
        send_query(16'sd1, 14'd4095);
        send_query(-16'sd100, 14'd4095);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 30 : 0;
            for (int i = 0; i < 480; i++) send_random_query();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== fresnel_reflectance.f =====
+incdir+hw/rtl
hw/rtl/frsn_pkg.sv
hw/rtl/frsn_front.sv
hw/rtl/frsn_sqrt.sv
hw/rtl/frsn_div.sv
hw/rtl/fresnel_reflectance.sv
bench/fresnel_reflectance_tb.sv
